FILE: rtl/call_stack_exclusive_time_assert.svh
// assertion macros shared by the exclusive-time accumulator
`ifndef CALL_STACK_EXCLUSIVE_TIME_ASSERT_SVH
`define CALL_STACK_EXCLUSIVE_TIME_ASSERT_SVH

// condition holds at every edge out of reset
`define CSET_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define CSET_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define CSET_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cset_pkg.sv
// package with sizes, payload types and pipeline records of the exclusive-time accumulator
package cset_pkg;

    localparam int MAX_FUNCS      = 64;
    localparam int STACK_DEPTH    = 64;
    localparam int ID_W           = 6;
    localparam int TIME_W         = 32;
    localparam int CNT_W          = 7;
    localparam int SP_W           = $clog2(STACK_DEPTH);
    localparam int DEPTH_W        = $clog2(STACK_DEPTH + 1);
    localparam int AMT_W          = TIME_W + 1;
    localparam int DIFF_W         = TIME_W + 2;
    localparam int SUM_W          = TIME_W + 2;
    localparam int OUT_FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W     = $clog2(OUT_FIFO_DEPTH);
    localparam int FIFO_CNT_W     = $clog2(OUT_FIFO_DEPTH + 1) + 1;

    localparam logic [CNT_W-1:0] FCOUNT_RESET = CNT_W'(MAX_FUNCS);

    // one log event
    typedef struct packed {
        logic [ID_W-1:0]   func_id;
        logic              is_end;
        logic [TIME_W-1:0] timestamp;
        logic              first_of_run;
    } in_item_t;

    // one credit report
    typedef struct packed {
        logic              credited;
        logic [ID_W-1:0]   credited_id;
        logic [TIME_W-1:0] credited_total;
        logic              fault;
    } out_item_t;

    // stage waiting on the stack read
    typedef struct packed {
        logic              valid;
        logic              first_of_run;
        logic              have;
        logic              use_top;
        logic [ID_W-1:0]   who;
        logic [AMT_W-1:0]  amt;
        logic              fault;
    } fetch_stage_t;

    // stage waiting on the totals read
    typedef struct packed {
        logic              valid;
        logic              first_of_run;
        logic              credit;
        logic [ID_W-1:0]   who;
        logic [AMT_W-1:0]  amt;
        logic              fault;
    } accum_stage_t;

endpackage

FILE: rtl/call_stack_exclusive_time.sv
// exclusive-time accumulator: call stack and per-function totals in synchronous memories
//
//  channel   signals                          direction  transfer when
//  item      item_valid item_ready item       in         item_valid && item_ready
//  result    result_valid result_ready result out        result_valid && result_ready
//  config    cfg_we cfg_wdata                 in         cfg_we (function_count)
//
// One event per cycle while item_ready is high. In the accepting cycle stage a pushes or pops
// and reads the stack top, stage b then picks the credited id and reads its total, and stage c adds,
// saturates and writes it back, with a one-entry bypass for a total written in the cycle before.
// A result is written into the queue from stage c and is offered once the queue count holds it.
// Reset clears stack depth, previous event, total valid bits and queue; memories keep contents.
// item_ready drops when the four-entry result queue could not take everything in flight.

`include "call_stack_exclusive_time_assert.svh"

module call_stack_exclusive_time (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  cset_pkg::in_item_t              item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output cset_pkg::out_item_t             result,
    input  logic                            cfg_we,
    input  logic [cset_pkg::CNT_W-1:0]      cfg_wdata
);

    // configuration and architectural state
    logic [cset_pkg::CNT_W-1:0]   fcount_reg;
    logic [cset_pkg::DEPTH_W-1:0] depth_reg, depth_next;
    logic [cset_pkg::ID_W-1:0]    prev_id_reg, prev_id_next;
    logic                         prev_end_reg, prev_end_next;
    logic [cset_pkg::TIME_W-1:0]  prev_time_reg, prev_time_next;
    logic [cset_pkg::MAX_FUNCS-1:0] total_valid_reg, total_valid_next;

    // memories
    logic [cset_pkg::ID_W-1:0]    stack_mem [cset_pkg::STACK_DEPTH];
    logic [cset_pkg::TIME_W-1:0]  totals_mem [cset_pkg::MAX_FUNCS];
    logic [cset_pkg::ID_W-1:0]    stk_rdata_reg;
    logic [cset_pkg::TIME_W-1:0]  tot_rdata_reg;

    // pipeline stages and bypass
    cset_pkg::fetch_stage_t       b_reg, b_next;
    cset_pkg::accum_stage_t       c_reg, c_next;
    logic                         fwd_valid_reg;
    logic [cset_pkg::ID_W-1:0]    fwd_id_reg;
    logic [cset_pkg::TIME_W-1:0]  fwd_data_reg;

    // result queue
    cset_pkg::out_item_t          fifo_mem [cset_pkg::OUT_FIFO_DEPTH];
    logic [cset_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [cset_pkg::FIFO_CNT_W-1:0] count_reg, count_next;
    logic [cset_pkg::FIFO_CNT_W-1:0] inflight;

    // stage a signals
    logic                         accept;
    logic                         in_range;
    logic [cset_pkg::DEPTH_W-1:0] depth_eff;
    logic                         have_a, use_top_a, plus_a, minus_a, fault_a;
    logic [cset_pkg::ID_W-1:0]    who_a;
    logic [cset_pkg::DIFF_W-1:0]  diff_a;
    logic [cset_pkg::AMT_W-1:0]   amt_a;
    logic                         stk_we;
    logic [cset_pkg::SP_W-1:0]    stk_waddr, stk_raddr;

    // stage b and c signals
    logic [cset_pkg::ID_W-1:0]    who_b;
    logic                         who_fault_b;
    logic [cset_pkg::TIME_W-1:0]  base_c;
    logic [cset_pkg::SUM_W-1:0]   sum_c;
    logic [cset_pkg::TIME_W-1:0]  total_c;
    logic                         tot_we;
    cset_pkg::out_item_t          res_c;
    logic                         pop;

    // flow control: everything in flight must fit in the result queue
    assign inflight   = count_reg + cset_pkg::FIFO_CNT_W'(b_reg.valid)
                      + cset_pkg::FIFO_CNT_W'(c_reg.valid);
    assign item_ready = (inflight < cset_pkg::FIFO_CNT_W'(cset_pkg::OUT_FIFO_DEPTH));
    assign accept     = item_valid && item_ready;

    // stage a: range check, case selection, gap and stack update
    always_comb
    begin
        depth_eff      = item.first_of_run ? '0 : depth_reg;
        in_range       = ({1'b0, item.func_id} < fcount_reg);
        have_a         = 1'b0;
        use_top_a      = 1'b0;
        plus_a         = 1'b0;
        minus_a        = 1'b0;
        who_a          = prev_id_reg;
        fault_a        = 1'b0;
        stk_we         = 1'b0;
        stk_waddr      = depth_eff[cset_pkg::SP_W-1:0];
        stk_raddr      = cset_pkg::SP_W'(depth_eff - cset_pkg::DEPTH_W'(1));
        depth_next     = depth_reg;
        prev_id_next   = prev_id_reg;
        prev_end_next  = prev_end_reg;
        prev_time_next = prev_time_reg;

        // choose who gains the elapsed time
        if (in_range && !item.first_of_run)
        begin
            if (!prev_end_reg && item.is_end && prev_id_reg == item.func_id)
            begin
                have_a = 1'b1;
                plus_a = 1'b1;
            end
            else if (!prev_end_reg && !item.is_end)
            begin
                have_a = 1'b1;
            end
            else if (prev_end_reg && item.is_end)
            begin
                have_a = 1'b1;
                who_a  = item.func_id;
            end
            else if (prev_end_reg && !item.is_end && depth_eff != '0)
            begin
                have_a    = 1'b1;
                use_top_a = 1'b1;
                minus_a   = 1'b1;
            end
        end

        // gap with adjustment, negative taken as zero
        diff_a = {2'b00, item.timestamp} - {2'b00, prev_time_reg}
               + cset_pkg::DIFF_W'(plus_a) - cset_pkg::DIFF_W'(minus_a);
        amt_a  = diff_a[cset_pkg::DIFF_W-1] ? '0 : diff_a[cset_pkg::AMT_W-1:0];

        // push, pop and previous event
        if (accept)
        begin
            if (!in_range)
            begin
                fault_a = 1'b1;
                if (item.first_of_run)
                begin
                    depth_next = '0;
                end
            end
            else
            begin
                if (item.is_end)
                begin
                    if (depth_eff == '0)
                    begin
                        fault_a    = 1'b1;
                        depth_next = depth_eff;
                    end
                    else
                    begin
                        depth_next = depth_eff - cset_pkg::DEPTH_W'(1);
                    end
                end
                else
                begin
                    if (depth_eff == cset_pkg::DEPTH_W'(cset_pkg::STACK_DEPTH))
                    begin
                        fault_a    = 1'b1;
                        depth_next = depth_eff;
                    end
                    else
                    begin
                        stk_we     = 1'b1;
                        depth_next = depth_eff + cset_pkg::DEPTH_W'(1);
                    end
                end
                prev_id_next   = item.func_id;
                prev_end_next  = item.is_end;
                prev_time_next = item.timestamp;
            end
        end

        b_next.valid        = accept;
        b_next.first_of_run = item.first_of_run;
        b_next.have         = have_a;
        b_next.use_top      = use_top_a;
        b_next.who          = who_a;
        b_next.amt          = amt_a;
        b_next.fault        = fault_a;
    end

    // stack memory: push write and top read in the accepting cycle
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_waddr] <= item.func_id;
        end
        stk_rdata_reg <= stack_mem[stk_raddr];
    end

    // stage b: resolve the credited id and check it against the limit
    always_comb
    begin
        who_b       = b_reg.use_top ? stk_rdata_reg : b_reg.who;
        who_fault_b = b_reg.have && !({1'b0, who_b} < fcount_reg);

        c_next.valid        = b_reg.valid;
        c_next.first_of_run = b_reg.first_of_run;
        c_next.credit       = b_reg.have && !who_fault_b;
        c_next.who          = who_b;
        c_next.amt          = b_reg.amt;
        c_next.fault        = b_reg.fault || who_fault_b;
    end

    // stage c: bypass, add, saturate
    always_comb
    begin
        if (fwd_valid_reg && fwd_id_reg == c_reg.who)
        begin
            base_c = fwd_data_reg;
        end
        else if (total_valid_reg[c_reg.who])
        begin
            base_c = tot_rdata_reg;
        end
        else
        begin
            base_c = '0;
        end
        sum_c   = {2'b00, base_c} + {1'b0, c_reg.amt};
        total_c = (sum_c[cset_pkg::SUM_W-1:cset_pkg::TIME_W] != '0) ? '1
                : sum_c[cset_pkg::TIME_W-1:0];
        tot_we  = c_reg.valid && c_reg.credit;

        res_c.credited       = c_reg.credit;
        res_c.credited_id    = c_reg.credit ? c_reg.who : '0;
        res_c.credited_total = c_reg.credit ? total_c : '0;
        res_c.fault          = c_reg.fault;

        // valid bits: run start clears, a credit marks its entry
        total_valid_next = total_valid_reg;
        if (c_reg.valid && c_reg.first_of_run)
        begin
            total_valid_next = '0;
        end
        else if (tot_we)
        begin
            total_valid_next[c_reg.who] = 1'b1;
        end
    end

    // totals memory: read in stage b, write back in stage c
    always_ff @(posedge clk)
    begin
        if (tot_we)
        begin
            totals_mem[c_reg.who] <= total_c;
        end
        tot_rdata_reg <= totals_mem[who_b];
    end

    // result queue
    assign pop          = result_valid && result_ready;
    assign result_valid = (count_reg != '0);
    assign result       = fifo_mem[rd_ptr_reg];
    assign count_next   = count_reg + cset_pkg::FIFO_CNT_W'(c_reg.valid)
                        - cset_pkg::FIFO_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (c_reg.valid)
        begin
            fifo_mem[wr_ptr_reg] <= res_c;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcount_reg      <= cset_pkg::FCOUNT_RESET;
            depth_reg       <= '0;
            prev_id_reg     <= '0;
            prev_end_reg    <= 1'b0;
            prev_time_reg   <= '0;
            total_valid_reg <= '0;
            b_reg           <= '0;
            c_reg           <= '0;
            fwd_valid_reg   <= 1'b0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                fcount_reg <= cfg_wdata;
            end
            depth_reg       <= depth_next;
            prev_id_reg     <= prev_id_next;
            prev_end_reg    <= prev_end_next;
            prev_time_reg   <= prev_time_next;
            total_valid_reg <= total_valid_next;
            b_reg           <= b_next;
            c_reg           <= c_next;
            fwd_valid_reg   <= tot_we;
            if (c_reg.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + cset_pkg::FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + cset_pkg::FIFO_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // bypass payload
    always_ff @(posedge clk)
    begin
        fwd_id_reg   <= c_reg.who;
        fwd_data_reg <= total_c;
    end

    // checks
    `CSET_ASSERT_HOLDS(a_depth_bound,
        depth_reg <= cset_pkg::DEPTH_W'(cset_pkg::STACK_DEPTH), "stack depth beyond capacity")
    `CSET_ASSERT_HOLDS(a_queue_room,
        inflight <= cset_pkg::FIFO_CNT_W'(cset_pkg::OUT_FIFO_DEPTH),
        "results in flight exceed queue room")
    `CSET_ASSERT_IMPLIES(a_quiet_result, result_valid && !result.credited,
        result.credited_id == '0 && result.credited_total == '0,
        "uncredited result carries id or total")
    `CSET_ASSERT_NEXT(a_run_clear, c_reg.valid && c_reg.first_of_run,
        total_valid_reg == '0, "run start left a total marked valid")
    `CSET_ASSERT_NEXT(a_credit_marks, tot_we,
        fwd_valid_reg && total_valid_reg[fwd_id_reg], "credited total not marked valid")

endmodule
